/* rtl/gradient_stop_interpolator_core_defines.svh */
// Assertion macros for the gradient stop interpolator
`ifndef GRADIENT_STOP_INTERPOLATOR_CORE_DEFINES_SVH
`define GRADIENT_STOP_INTERPOLATOR_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define GSI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gsi assertion failed");
// Assert that an antecedent implies a consequent in the next cycle
`define GSI_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gsi assertion failed");
`endif

/* rtl/gsi_pkg.sv */
// ----------------------------------------------------------------------------
// gsi_pkg
// Shared constants, types and codes for the gradient stop interpolator.
// ----------------------------------------------------------------------------
package gsi_pkg;
  localparam int DEF_MAX_STOPS    = 16;
  localparam int DEF_MAX_CHANNELS = 8;
  localparam int NUM_OUT          = 8;
  localparam int VW               = 16;
  localparam int FW               = 17;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;
  localparam logic [3:0] WORD_LOC = 4'd8;

  localparam logic [0:0] REG_STOP_COUNT     = 1'd0;
  localparam logic [0:0] REG_COLOR_CHANNELS = 1'd1;

  typedef logic [VW-1:0] val_t;
  typedef val_t [NUM_OUT-1:0] chan_vec_t;
endpackage

/* rtl/gsi_divider.sv */
// ----------------------------------------------------------------------------
// gsi_divider
// Pipelined restoring divider: one quotient bit per stage, stalls as a unit.
// ----------------------------------------------------------------------------
module gsi_divider
  import gsi_pkg::*;
#(
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] num,
  input  logic [VW-1:0] den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [FW-1:0] quo,
  output logic [TW-1:0] out_tag,
  output logic          busy
);
  // dividend is num << 16 with num <= den, so the quotient fits 17 bits;
  // seed the remainder with num >> 1 so the first stage yields quotient bit 16
  localparam int NS = FW;
  logic [NS:0]           vld;
  logic [VW:0]           rem   [NS+1];
  logic [FW-1:0]         q     [NS+1];
  logic [VW-1:0]         dv    [NS+1];
  logic [VW-1:0]         nm    [NS+1];
  logic [TW-1:0]         tg    [NS+1];

  assign vld[0] = in_valid;
  assign rem[0] = {2'b0, num[VW-1:1]};
  assign q[0]   = '0;
  assign dv[0]  = den;
  assign nm[0]  = num;
  assign tg[0]  = in_tag;

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [VW+1:0] trial;
    logic [VW:0]   sh;
    always_comb begin
      // dividend bit: numerator bit 0 first, then zeros
      sh    = {rem[s][VW-1:0], (s == 0) ? nm[s][0] : 1'b0};
      trial = {1'b0, sh} - {2'b0, dv[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else if (en) vld[s+1] <= vld[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= trial[VW+1] ? sh : trial[VW:0];
        q[s+1]   <= {q[s][FW-2:0], ~trial[VW+1]};
        dv[s+1]  <= dv[s];
        nm[s+1]  <= nm[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo       = q[NS];
  assign out_tag   = tg[NS];
  assign busy      = |vld[NS:1];
endmodule

/* rtl/gsi_lerp.sv */
// ----------------------------------------------------------------------------
// gsi_lerp
// Two-stage channel blend: products registered, then summed and shifted.
// ----------------------------------------------------------------------------
module gsi_lerp
  import gsi_pkg::*;
(
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] b,
  input  logic [FW-1:0] f,
  output logic [VW-1:0] y
);
  logic [VW+FW-1:0] pa, pb;
  logic [VW+FW:0]   sum;
  logic [FW-1:0]    g;

  assign g   = FW'(17'h10000) - f;
  assign sum = {1'b0, pa} + {1'b0, pb};

  // multiply, then add and drop the fraction
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= a * g;
      pb <= b * f;
      y  <= sum[VW+VW-1:VW];
    end
  end
endmodule

/* rtl/gradient_stop_interpolator_core.sv */
// gradient_stop_interpolator_core
// Pipeline: search, divide, table read, blend, output register. Throughput: one
// evaluate per cycle while the output is not stalled; a write waits while an
// evaluate is ahead of the table read. The pipeline advances when the output
// register is free.
// Reset: synchronous; clears valid bits and registers (stop_count 2,
// color_channels 3); stop tables are undefined until written.
`include "gradient_stop_interpolator_core_defines.svh"
module gradient_stop_interpolator_core
  import gsi_pkg::*;
#(
  parameter int MAX_STOPS    = DEF_MAX_STOPS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  output logic         ready,
  input  logic         cmd,
  input  logic [3:0]   stop_index,
  input  logic [3:0]   word_index,
  input  logic [15:0]  word_value,
  input  logic [15:0]  position,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  channel_0,
  output logic [15:0]  channel_1,
  output logic [15:0]  channel_2,
  output logic [15:0]  channel_3,
  output logic [15:0]  channel_4,
  output logic [15:0]  channel_5,
  output logic [15:0]  channel_6,
  output logic [15:0]  channel_7,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [4:0]   cfg_data
);
  localparam int SW = $clog2(MAX_STOPS);
  localparam int TAGW = SW + 1;

  logic [4:0] stop_count;
  logic [2:0] color_channels;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count     <= 5'd2;
      color_channels <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STOP_COUNT:     stop_count     <= cfg_data;
        REG_COLOR_CHANNELS: color_channels <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // active stop count, clamped; last index
  logic [SW:0]   n_act;
  logic [SW-1:0] last;
  logic [3:0]    act_ch;
  always_comb begin
    if (stop_count == 5'd0) n_act = (SW+1)'(1);
    else if (32'(stop_count) > MAX_STOPS) n_act = (SW+1)'(MAX_STOPS);
    else n_act = (SW+1)'(stop_count);
    last = SW'(n_act - 1'b1);
    if (32'(color_channels) + 1 > MAX_CHANNELS) act_ch = 4'(MAX_CHANNELS);
    else act_ch = {1'b0, color_channels} + 4'd1;
  end

  logic en;
  logic acc;
  logic busy;
  // hold writes while an evaluate still reads the tables ahead of them
  assign ready = en && !(cmd == CMD_WRITE && busy);
  assign acc   = valid && ready;

  // location table in flops; channel values in per-channel memories below
  logic [VW-1:0] loc [MAX_STOPS];
  logic wr_ok;
  assign wr_ok = acc && (cmd == CMD_WRITE) && (32'(stop_index) < MAX_STOPS);

  always_ff @(posedge clk) begin
    if (wr_ok && word_index == WORD_LOC) loc[SW'(stop_index)] <= word_value;
  end

  // stage 1: per-stop compare bits
  logic          s1_v;
  logic [VW-1:0] s1_t;
  logic [MAX_STOPS-1:0] s1_ge;
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= acc && (cmd == CMD_EVAL);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_t <= position;
      for (int i = 0; i < MAX_STOPS; i++) s1_ge[i] <= (loc[i] >= position);
    end
  end

  // stage 2: classify and locate first stop at or above t
  logic          s2_v, s2_clamp;
  logic [SW-1:0] s2_lo, s2_sel;
  logic [VW-1:0] s2_t;
  logic [SW-1:0] c_lo;
  logic          c_found;
  logic [MAX_STOPS-1:0] act_mask;
  always_comb begin
    c_lo = '0;
    c_found = 1'b0;
    for (int i = MAX_STOPS-1; i >= 1; i--) begin
      act_mask[i] = (i < 32'(n_act));
      if (act_mask[i] && s1_ge[i]) begin
        c_lo = SW'(i - 1);
        c_found = 1'b1;
      end
    end
    act_mask[0] = 1'b1;
  end
  logic lo_clamp, hi_clamp;
  assign lo_clamp = (s1_t <= loc[0]);
  assign hi_clamp = (s1_t >= loc[last]);
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_t     <= s1_t;
      s2_clamp <= lo_clamp || hi_clamp || !c_found;
      s2_sel   <= lo_clamp ? '0 : last;
      s2_lo    <= c_lo;
    end
  end

  // stage 3: fetch span and offset
  logic          s3_v, s3_clamp;
  logic [SW-1:0] s3_lo;
  logic [VW-1:0] s3_num, s3_den;
  logic [SW-1:0] hi_i;
  assign hi_i = s2_lo + 1'b1;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_clamp <= s2_clamp;
      s3_lo    <= s2_clamp ? s2_sel : s2_lo;
      s3_den   <= (loc[hi_i] > loc[s2_lo]) ? loc[hi_i] - loc[s2_lo] : '0;
      s3_num   <= (s2_t > loc[s2_lo]) ? s2_t - loc[s2_lo] : '0;
    end
  end

  // divide; zero span and clamps give f = 0
  logic            d_v;
  logic [FW-1:0]   d_q;
  logic [TAGW-1:0] d_tag;
  logic            div_busy;
  gsi_divider #(.TW(TAGW)) u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(s3_v),
    .num(s3_num), .den(s3_den),
    .in_tag({s3_clamp || s3_den == '0 || s3_num == '0, s3_lo}),
    .out_valid(d_v), .quo(d_q), .out_tag(d_tag), .busy(div_busy)
  );

  // the table read at the fraction stage sees values from before a write
  // accepted at the same edge, so only the stages before it block writes
  assign busy = s1_v || s2_v || s3_v || div_busy;

  // stage: fraction and table read addresses
  logic          r_v;
  logic [FW-1:0] r_f;
  logic [SW-1:0] r_lo, r_hi;
  logic          r_clamp;
  assign r_clamp = d_tag[TAGW-1];
  always_ff @(posedge clk) begin
    if (rst) r_v <= 1'b0;
    else if (en) r_v <= d_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      r_f  <= r_clamp ? '0 : ((d_q > FW'(17'h10000)) ? FW'(17'h10000) : d_q);
      r_lo <= d_tag[TAGW-2 -: SW];
      r_hi <= r_clamp ? d_tag[TAGW-2 -: SW] : d_tag[TAGW-2 -: SW] + 1'b1;
    end
  end

  // registered memory reads follow the fraction
  logic          m_v;
  logic [FW-1:0] m_f;
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= r_v;
  end
  always_ff @(posedge clk) begin
    if (en) m_f <= r_f;
  end

  // blend lanes
  logic [VW-1:0] y [MAX_CHANNELS];
  logic [1:0]    b_v;
  always_ff @(posedge clk) begin
    if (rst) b_v <= '0;
    else if (en) b_v <= {b_v[0], m_v};
  end
  // one stop memory per channel, read at the lower and upper stop
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_ln
    logic [VW-1:0] vmem [MAX_STOPS];
    logic [VW-1:0] m_a, m_b;
    always_ff @(posedge clk) begin
      if (wr_ok && word_index == 4'(c)) vmem[SW'(stop_index)] <= word_value;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_a <= vmem[r_lo];
        m_b <= vmem[r_hi];
      end
    end
    gsi_lerp u_lerp (.clk(clk), .en(en), .a(m_a), .b(m_b), .f(m_f), .y(y[c]));
  end

  // output register; masks unused channels
  chan_vec_t o_ch;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= b_v[1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_OUT; c++)
        o_ch[c] <= (c < MAX_CHANNELS && c < 32'(act_ch)) ? y[(c < MAX_CHANNELS) ? c : 0] : '0;
    end
  end
  assign en = !out_valid || out_ready;

  assign channel_0 = o_ch[0];
  assign channel_1 = o_ch[1];
  assign channel_2 = o_ch[2];
  assign channel_3 = o_ch[3];
  assign channel_4 = o_ch[4];
  assign channel_5 = o_ch[5];
  assign channel_6 = o_ch[6];
  assign channel_7 = o_ch[7];

  // checks
  `GSI_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(o_ch))
  `GSI_ASSERT_IMP(a_frac, clk, rst, r_v, r_f <= FW'(17'h10000))
  `GSI_ASSERT_NEXT(a_stall, clk, rst, !en, $stable(m_v) && $stable(r_v))
endmodule
